>>> src/dsol_pkg.sv
package dsol_pkg;

  // List geometry
  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths
  localparam int ID_W     = 32;
  localparam int KEY_W    = 32;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int TOTAL_W  = 7;

  // Request types
  localparam logic [REQ_W-1:0] REQ_INSERT = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_REMOVE = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_UPDATE = REQ_W'(2);

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_DUP      = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_FULL     = STATUS_W'(3);

  // One list entry as stored
  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [KEY_W-1:0] key;
  } entry_t;

  // Memory access from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Signed key compare
  function automatic logic key_lt(input logic signed [KEY_W-1:0] a,
                                  input logic signed [KEY_W-1:0] b);
    return a < b;
  endfunction

endpackage

>>> src/dsol_mem.sv
module dsol_mem (
  input  logic              clk,
  input  dsol_pkg::mem_req_t mreq,
  output dsol_pkg::entry_t   rdata
);
  import dsol_pkg::*;

  entry_t mem [DEPTH];

  // One write port, one registered read port; read returns old data on a collision
  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.waddr] <= mreq.wdata;
    end
    rdata <= mem[mreq.raddr];
  end

endmodule

>>> src/dsol_ctrl.sv
module dsol_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [dsol_pkg::REQ_W-1:0]        req_type,
  input  logic [dsol_pkg::ID_W-1:0]         obj_id,
  input  logic signed [dsol_pkg::KEY_W-1:0] key_y,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [dsol_pkg::STATUS_W-1:0]     status,
  output logic [dsol_pkg::POS_W-1:0]        position,
  output logic [dsol_pkg::TOTAL_W-1:0]      entry_total,
  output dsol_pkg::mem_req_t                mreq,
  input  dsol_pkg::entry_t                  rdata
);
  import dsol_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_WALK_L = 3'd2;
  localparam logic [2:0] S_WALK_R = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]              state, state_next;
  logic [CNT_W-1:0]        ptr, ptr_next;
  logic [CNT_W-1:0]        hole, hole_next;
  logic [CNT_W-1:0]        count, count_next;
  logic                    first, first_next;
  logic [REQ_W-1:0]        req, req_next;
  logic [ID_W-1:0]         mov_id, mov_id_next;
  logic signed [KEY_W-1:0] mov_key, mov_key_next;
  logic [STATUS_W-1:0]     res_status, res_status_next;
  logic [CNT_W-1:0]        res_pos, res_pos_next;
  logic                    rsp_load;
  logic [CNT_W-1:0]        last;

  assign last      = count - CNT_W'(1);
  assign req_ready = (state == S_IDLE);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || rsp_ready);

  // Sequencer: id search, then one entry moved per cycle
  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    hole_next       = hole;
    count_next      = count;
    first_next      = first;
    req_next        = req;
    mov_id_next     = mov_id;
    mov_key_next    = mov_key;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    mreq            = '0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          req_next        = req_type;
          mov_id_next     = obj_id;
          mov_key_next    = key_y;
          ptr_next        = '0;
          first_next      = 1'b1;
          res_status_next = ST_OK;
          res_pos_next    = '0;
          if (req_type == REQ_INSERT || req_type == REQ_REMOVE ||
              req_type == REQ_UPDATE) begin
            state_next = S_SEARCH;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      S_SEARCH: begin
        priority if (ptr == count) begin
          // id not present
          if (req == REQ_INSERT) begin
            priority if (count == CNT_W'(DEPTH)) begin
              res_status_next = ST_FULL;
              state_next      = S_DONE;
            end else if (count == '0) begin
              hole_next  = '0;
              count_next = count + CNT_W'(1);
              state_next = S_FIN;
            end else begin
              hole_next  = count;
              ptr_next   = last;
              count_next = count + CNT_W'(1);
              state_next = S_WALK_L;
            end
          end else begin
            res_status_next = ST_NOTFOUND;
            state_next      = S_DONE;
          end
        end else if (rdata.id == mov_id) begin
          res_pos_next = ptr;
          hole_next    = ptr;
          unique case (req)
            REQ_INSERT: begin
              res_status_next = ST_DUP;
              state_next      = S_DONE;
            end
            REQ_REMOVE: begin
              if (ptr == last) begin
                count_next = last;
                state_next = S_DONE;
              end else begin
                ptr_next   = ptr + CNT_W'(1);
                state_next = S_SHIFT;
              end
            end
            default: begin
              priority if (ptr != last) begin
                ptr_next   = ptr + CNT_W'(1);
                state_next = S_WALK_R;
              end else if (ptr != '0) begin
                ptr_next   = ptr - CNT_W'(1);
                state_next = S_WALK_L;
              end else begin
                state_next = S_FIN;
              end
            end
          endcase
        end else begin
          ptr_next = ptr + CNT_W'(1);
        end
      end

      // rdata is the entry at ptr, hole is ptr + 1
      S_WALK_L: begin
        if (first ? key_lt(mov_key, rdata.key) : !key_lt(rdata.key, mov_key)) begin
          mreq.we    = 1'b1;
          mreq.waddr = IDX_W'(hole);
          mreq.wdata = rdata;
          hole_next  = ptr;
          first_next = 1'b0;
          if (ptr == '0) begin
            state_next = S_FIN;
          end else begin
            ptr_next = ptr - CNT_W'(1);
          end
        end else begin
          state_next = S_FIN;
        end
      end

      // rdata is the entry at ptr, hole is ptr - 1
      S_WALK_R: begin
        priority if (first ? key_lt(rdata.key, mov_key) : !key_lt(mov_key, rdata.key)) begin
          mreq.we    = 1'b1;
          mreq.waddr = IDX_W'(hole);
          mreq.wdata = rdata;
          hole_next  = ptr;
          first_next = 1'b0;
          if (ptr == last) begin
            state_next = S_FIN;
          end else begin
            ptr_next = ptr + CNT_W'(1);
          end
        end else if (first && hole != '0) begin
          // right neighbour not smaller: try the left side
          ptr_next   = hole - CNT_W'(1);
          state_next = S_WALK_L;
        end else begin
          state_next = S_FIN;
        end
      end

      // Remove: close the gap one entry per cycle
      S_SHIFT: begin
        mreq.we    = 1'b1;
        mreq.waddr = IDX_W'(ptr - CNT_W'(1));
        mreq.wdata = rdata;
        if (ptr == last) begin
          count_next = last;
          state_next = S_DONE;
        end else begin
          ptr_next = ptr + CNT_W'(1);
        end
      end

      // Drop the moving entry into its hole
      S_FIN: begin
        mreq.we      = 1'b1;
        mreq.waddr   = IDX_W'(hole);
        mreq.wdata   = '{id: mov_id, key: mov_key};
        res_pos_next = hole;
        state_next   = S_DONE;
      end

      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    mreq.raddr = IDX_W'(ptr_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      first <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      first <= first_next;
    end
    ptr        <= ptr_next;
    hole       <= hole_next;
    req        <= req_next;
    mov_id     <= mov_id_next;
    mov_key    <= mov_key_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (rsp_load) begin
      status      <= res_status;
      position    <= POS_W'(res_pos);
      entry_total <= TOTAL_W'(count);
    end
  end

endmodule

>>> src/depth_sorted_object_list_core.sv
// Depth-sorted object list: holds up to 64 objects (32-bit id, signed Q16.16
// key) in ascending key order in one single-port-read RAM. Each request
// (insert, remove by id, update key by id) gives one result: status, final or
// removed index, and the entry count after the request. Requests are handled
// one at a time. A request first scans the list for its id at one entry per
// cycle, then insert and update move the entry one neighbour per cycle and
// remove shifts the tail left one entry per cycle; insert and update then
// place the entry, and the result is registered. The pace is set by the one
// read and one write port of the entry RAM. A waiting result sits in the
// output register and the next request is taken once it has been loaded
// there. No clearing pass after reset: entries beyond the count are never
// read for a result.
module depth_sorted_object_list_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [dsol_pkg::REQ_W-1:0]        req_type,
  input  logic [dsol_pkg::ID_W-1:0]         obj_id,
  input  logic signed [dsol_pkg::KEY_W-1:0] key_y,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [dsol_pkg::STATUS_W-1:0]     status,
  output logic [dsol_pkg::POS_W-1:0]        position,
  output logic [dsol_pkg::TOTAL_W-1:0]      entry_total
);
  import dsol_pkg::*;

  mem_req_t mreq;
  entry_t   rdata;

  dsol_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_type    (req_type),
    .obj_id      (obj_id),
    .key_y       (key_y),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .position    (position),
    .entry_total (entry_total),
    .mreq        (mreq),
    .rdata       (rdata)
  );

  dsol_mem u_mem (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (rdata)
  );

endmodule

>>> src/dsol_checker.sv
module dsol_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic [dsol_pkg::STATUS_W-1:0]     status,
  input logic [dsol_pkg::POS_W-1:0]        position,
  input logic [dsol_pkg::TOTAL_W-1:0]      entry_total
);
  import dsol_pkg::*;

  // One request at a time: no request taken right after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one in flight");

  // Full only reported with the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> entry_total == TOTAL_W'(DEPTH))
    else $error("full status with free entries");

  // Missing id or full list gives index zero
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_NOTFOUND || status == ST_FULL) |-> position == '0)
    else $error("nonzero position on failed request");

  // Count never exceeds capacity
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> entry_total <= TOTAL_W'(DEPTH))
    else $error("entry total above capacity");

  // Stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(position)
      && $stable(entry_total))
    else $error("stalled result changed");

endmodule

bind depth_sorted_object_list_core dsol_checker u_dsol_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_ready   (req_ready),
  .rsp_valid   (rsp_valid),
  .rsp_ready   (rsp_ready),
  .status      (status),
  .position    (position),
  .entry_total (entry_total)
);
